@@ hdl/prmt_pkg.sv @@
// ----------------------------------------------------------------------------
// prmt_pkg: shared types and codes for the packet replica merge table
// Arrival port codes, result codes and the table update bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prmt_pkg;

    // fixed field widths
    localparam int PORT_W   = 3;
    localparam int ID_W     = 16;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 3;

    // arrival port codes
    localparam logic [PORT_W-1:0] IN_CLIENT       = 3'd0;
    localparam logic [PORT_W-1:0] IN_P1_TO_SERVER = 3'd1;
    localparam logic [PORT_W-1:0] IN_P2_TO_SERVER = 3'd2;
    localparam logic [PORT_W-1:0] IN_SERVER       = 3'd3;
    localparam logic [PORT_W-1:0] IN_P1_TO_CLIENT = 3'd4;
    localparam logic [PORT_W-1:0] IN_P2_TO_CLIENT = 3'd5;

    // configuration register indexes
    localparam int REG_COPIES_NEEDED = 0;
    localparam logic [COUNT_W-1:0] COPIES_RESET = 8'd2;

    // departure port codes
    typedef enum logic [PORT_W-1:0] {
        OUT_MIRROR1 = 3'd0,
        OUT_DROP    = 3'd1,
        OUT_SERVER  = 3'd2,
        OUT_MIRROR2 = 3'd3,
        OUT_CLIENT  = 3'd4
    } t_out_port;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_BADPORT = 3'd4,
        ST_WAIT    = 3'd5
    } t_status;

    // table update and result for one item
    typedef struct packed {
        logic                cnt_we;
        logic [COUNT_W-1:0]  cnt_wdata;
        logic                hdl_we;
        logic [HANDLE_W-1:0] hdl_wdata;
        logic                live_inc;
        logic                live_dec;
        t_out_port           out_port;
        logic [HANDLE_W-1:0] out_handle;
        logic                rel_valid;
        logic [HANDLE_W-1:0] rel_handle;
        t_status             status;
    } t_upd_res;

endpackage

@@ hdl/packet_replica_merge_table_core.sv @@
// ----------------------------------------------------------------------------
// packet_replica_merge_table_core: replica merge table, top level
// An accepted item's entry is read into the ram read registers as the item
// enters the lookup stage; its update goes into the output register once that
// register is free. Throughput: 1 item per cycle while results are taken; the
// table memories take one read and one write per cycle, with write-to-read
// forwarding on the same entry. Reset: after i_rst_n the count table is swept
// to zero, one entry per cycle, o_in_ready low; config writes work throughout.
// TABLE_DEPTH must be a power of two; the entry index is the low id bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_replica_merge_table_core import prmt_pkg::*; #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input items
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [PORT_W-1:0]   i_in_port,
    input  logic [ID_W-1:0]     i_packet_id,
    input  logic [HANDLE_W-1:0] i_packet_handle,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [PORT_W-1:0]   o_out_port,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic                o_released_valid,
    output logic [HANDLE_W-1:0] o_released_handle,
    output logic [STATUS_W-1:0] o_status
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int LIVE_W = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [2:0] COPIES_ADDR = 3'(4 * REG_COPIES_NEEDED);

    // configuration register
    logic [COUNT_W-1:0] r_copies;

    // clearing sweep
    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;

    // lookup stage
    logic                r_busy;
    logic [PORT_W-1:0]   r_port;
    logic [ADDR_W-1:0]   r_idx;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_fwd_cnt_v;
    logic [COUNT_W-1:0]  r_fwd_cnt;
    logic                r_fwd_hdl_v;
    logic [HANDLE_W-1:0] r_fwd_hdl;

    logic [LIVE_W-1:0] r_live;

    // output register
    logic                r_out_valid;
    logic [PORT_W-1:0]   r_out_port;
    logic [HANDLE_W-1:0] r_out_handle;
    logic                r_rel_valid;
    logic [HANDLE_W-1:0] r_rel_handle;
    logic [STATUS_W-1:0] r_status;

    logic                w_accept;
    logic                w_fire;
    logic [ADDR_W-1:0]   w_in_idx;
    logic [COUNT_W-1:0]  w_cnt_rd;
    logic [HANDLE_W-1:0] w_hdl_rd;
    logic [COUNT_W-1:0]  w_cnt;
    logic [HANDLE_W-1:0] w_hdl;
    logic                w_cnt_we;
    logic [ADDR_W-1:0]   w_cnt_waddr;
    logic [COUNT_W-1:0]  w_cnt_wdata;
    t_upd_res            w_res;

    // handshake
    assign w_in_idx   = i_packet_id[ADDR_W-1:0];
    assign w_fire     = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_active && (!r_busy || w_fire);
    assign w_accept   = i_in_valid && o_in_ready;

    // apb register access
    assign pready = 1'b1;
    assign prdata = (paddr == COPIES_ADDR) ? {{(32 - COUNT_W){1'b0}}, r_copies} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copies <= COPIES_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == COPIES_ADDR)) begin
            r_copies <= pwdata[COUNT_W-1:0];
        end
    end

    // count table clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // count table write mux: sweep or update
    assign w_cnt_we    = r_clr_active || (w_fire && w_res.cnt_we);
    assign w_cnt_waddr = r_clr_active ? r_clr_addr : r_idx;
    assign w_cnt_wdata = r_clr_active ? '0 : w_res.cnt_wdata;

    prmt_ram #(
        .DATA_W (COUNT_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_idx),
        .o_rdata (w_cnt_rd)
    );

    prmt_ram #(
        .DATA_W (HANDLE_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_hdl_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire && w_res.hdl_we),
        .i_waddr (r_idx),
        .i_wdata (w_res.hdl_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_idx),
        .o_rdata (w_hdl_rd)
    );

    // entry seen by the update, with forwarded write-back
    assign w_cnt = r_fwd_cnt_v ? r_fwd_cnt : w_cnt_rd;
    assign w_hdl = r_fwd_hdl_v ? r_fwd_hdl : w_hdl_rd;

    prmt_update #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LIVE_W      (LIVE_W)
    ) u_update (
        .i_port   (r_port),
        .i_handle (r_handle),
        .i_cnt    (w_cnt),
        .i_stored (w_hdl),
        .i_live   (r_live),
        .i_copies (r_copies),
        .o_res    (w_res)
    );

    // lookup stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fwd_cnt_v <= 1'b0;
            r_fwd_hdl_v <= 1'b0;
        end else if (w_accept) begin
            r_busy      <= 1'b1;
            r_fwd_cnt_v <= w_fire && w_res.cnt_we && (r_idx == w_in_idx);
            r_fwd_hdl_v <= w_fire && w_res.hdl_we && (r_idx == w_in_idx);
        end else if (w_fire) begin
            r_busy <= 1'b0;
        end
    end

    // lookup stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_port    <= i_in_port;
            r_idx     <= w_in_idx;
            r_handle  <= i_packet_handle;
            r_fwd_cnt <= w_res.cnt_wdata;
            r_fwd_hdl <= w_res.hdl_wdata;
        end
    end

    // live entry counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (w_fire) begin
            if (w_res.live_inc) begin
                r_live <= r_live + LIVE_W'(1);
            end else if (w_res.live_dec) begin
                r_live <= r_live - LIVE_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_port   <= w_res.out_port;
            r_out_handle <= w_res.out_handle;
            r_rel_valid  <= w_res.rel_valid;
            r_rel_handle <= w_res.rel_handle;
            r_status     <= w_res.status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_port        = r_out_port;
    assign o_out_handle      = r_out_handle;
    assign o_released_valid  = r_rel_valid;
    assign o_released_handle = r_rel_handle;
    assign o_status          = r_status;

    // checks
    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (!o_in_ready && !r_busy))
        else $error("item taken during table clearing");

    a_live_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LIVE_W'(TABLE_DEPTH))
        else $error("live entry count beyond table depth");

    a_fire_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("finished item did not reach output register");

    a_release_only_on_ok_or_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_released_valid) |-> (o_status == ST_OK || o_status == ST_WAIT))
        else $error("handle released on a failed lookup");

endmodule

@@ hdl/prmt_ram.sv @@
// ----------------------------------------------------------------------------
// prmt_ram: simple dual-port synchronous ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prmt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/prmt_update.sv @@
// ----------------------------------------------------------------------------
// prmt_update: entry update decision
// Given one item and its table entry, decides the write-back and the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prmt_update import prmt_pkg::*; #(
    parameter int TABLE_DEPTH = 65536,
    parameter int LIVE_W      = 17
) (
    input  logic [PORT_W-1:0]   i_port,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [COUNT_W-1:0]  i_cnt,
    input  logic [HANDLE_W-1:0] i_stored,
    input  logic [LIVE_W-1:0]   i_live,
    input  logic [COUNT_W-1:0]  i_copies,
    output t_upd_res            o_res
);

    localparam logic [LIVE_W-1:0] FULL_COUNT = LIVE_W'(TABLE_DEPTH);

    logic [COUNT_W-1:0] w_dec;
    logic               w_live_nz;

    assign w_dec     = i_cnt - COUNT_W'(1);
    assign w_live_nz = (i_live != '0);

    always_comb begin
        o_res            = '0;
        o_res.out_port   = OUT_DROP;
        o_res.out_handle = i_handle;
        o_res.status     = ST_OK;
        o_res.hdl_wdata  = i_handle;
        o_res.cnt_wdata  = w_dec;

        case (i_port) inside
            // opening packet from client or server
            IN_CLIENT, IN_SERVER: begin
                if (i_live >= FULL_COUNT) begin
                    o_res.status = ST_FULL;
                end else if (i_cnt != '0) begin
                    o_res.status = ST_DUP;
                end else begin
                    o_res.cnt_we    = 1'b1;
                    o_res.cnt_wdata = (i_copies != '0) ? i_copies : COUNT_W'(1);
                    o_res.hdl_we    = 1'b1;
                    o_res.live_inc  = 1'b1;
                    o_res.out_port  = (i_port == IN_CLIENT) ? OUT_MIRROR1 : OUT_MIRROR2;
                end
            end
            // path 1 replica: keeps the newest copy
            IN_P1_TO_SERVER, IN_P1_TO_CLIENT: begin
                if (i_cnt == '0) begin
                    o_res.status = ST_MISSING;
                end else begin
                    o_res.cnt_we     = 1'b1;
                    o_res.rel_valid  = 1'b1;
                    o_res.rel_handle = i_stored;
                    if (w_dec == '0) begin
                        o_res.live_dec = w_live_nz;
                        o_res.out_port = (i_port == IN_P1_TO_SERVER) ? OUT_SERVER
                                                                     : OUT_CLIENT;
                    end else begin
                        o_res.hdl_we = 1'b1;
                        o_res.status = ST_WAIT;
                    end
                end
            end
            // path 2 replica: forwards the stored copy on completion
            IN_P2_TO_SERVER, IN_P2_TO_CLIENT: begin
                if (i_cnt == '0) begin
                    o_res.status = ST_MISSING;
                end else begin
                    o_res.cnt_we = 1'b1;
                    if (w_dec == '0) begin
                        o_res.out_handle = i_stored;
                        o_res.rel_valid  = 1'b1;
                        o_res.rel_handle = i_handle;
                        o_res.live_dec   = w_live_nz;
                        o_res.out_port   = (i_port == IN_P2_TO_SERVER) ? OUT_SERVER
                                                                       : OUT_CLIENT;
                    end else begin
                        o_res.status = ST_WAIT;
                    end
                end
            end
            default: begin
                o_res.status = ST_BADPORT;
            end
        endcase
    end

endmodule

@@ tb/replica_merge_sb_pkg.sv @@
// ----------------------------------------------------------------------------
// replica_merge_sb_pkg: scoreboard for the packet replica merge table
// Keeps its own copy of the copy-count table, the held handles and the live
// entry count, predicts one verdict per accepted packet and checks each
// result item against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package replica_merge_sb_pkg;

    import prmt_pkg::*;

    localparam int TABLE_ENTRIES = 65536;
    localparam int MAX_REPORTS   = 50;

    // what the table decides for one packet
    typedef struct packed {
        t_out_port           port;
        logic [HANDLE_W-1:0] handle;
        logic                rel_valid;
        logic [HANDLE_W-1:0] rel_handle;
        t_status             status;
    } packet_verdict_t;

    class replica_merge_scoreboard;

        logic [COUNT_W-1:0]  copies_needed;
        logic [COUNT_W-1:0]  copies_left [TABLE_ENTRIES];
        logic [HANDLE_W-1:0] held_handle [TABLE_ENTRIES];
        int unsigned         live_entries;
        packet_verdict_t     expected_verdicts [$];
        int unsigned         errors;

        function new();
            copies_needed = COPIES_RESET;
            foreach (copies_left[i]) begin
                copies_left[i] = '0;
                held_handle[i] = '0;
            end
            live_entries = 0;
            errors       = 0;
        endfunction

        // predict the verdict of an accepted packet and update the table copy
        function void note_packet(input logic [PORT_W-1:0] port,
                                  input logic [ID_W-1:0] id,
                                  input logic [HANDLE_W-1:0] handle);
            packet_verdict_t v;
            v.port       = OUT_DROP;
            v.handle     = handle;
            v.rel_valid  = 1'b0;
            v.rel_handle = '0;
            v.status     = ST_OK;
            case (port)
                IN_CLIENT, IN_SERVER: begin
                    if (live_entries >= TABLE_ENTRIES) begin
                        v.status = ST_FULL;
                    end else if (copies_left[id] != '0) begin
                        v.status = ST_DUP;
                    end else begin
                        // zero copies behaves as one
                        copies_left[id] = (copies_needed == '0) ? 8'd1 : copies_needed;
                        held_handle[id] = handle;
                        live_entries++;
                        v.port = (port == IN_CLIENT) ? OUT_MIRROR1 : OUT_MIRROR2;
                    end
                end
                IN_P1_TO_SERVER, IN_P1_TO_CLIENT: begin
                    if (copies_left[id] == '0) begin
                        v.status = ST_MISSING;
                    end else begin
                        // path 1 swaps in its newest copy while waiting
                        copies_left[id] = copies_left[id] - 8'd1;
                        v.rel_valid     = 1'b1;
                        v.rel_handle    = held_handle[id];
                        if (copies_left[id] == '0) begin
                            if (live_entries > 0) live_entries--;
                            v.port = (port == IN_P1_TO_SERVER) ? OUT_SERVER : OUT_CLIENT;
                        end else begin
                            held_handle[id] = handle;
                            v.status        = ST_WAIT;
                        end
                    end
                end
                IN_P2_TO_SERVER, IN_P2_TO_CLIENT: begin
                    if (copies_left[id] == '0) begin
                        v.status = ST_MISSING;
                    end else begin
                        // path 2 forwards the held copy on completion
                        copies_left[id] = copies_left[id] - 8'd1;
                        if (copies_left[id] == '0) begin
                            v.handle     = held_handle[id];
                            v.rel_valid  = 1'b1;
                            v.rel_handle = handle;
                            if (live_entries > 0) live_entries--;
                            v.port = (port == IN_P2_TO_SERVER) ? OUT_SERVER : OUT_CLIENT;
                        end else begin
                            v.status = ST_WAIT;
                        end
                    end
                end
                default: begin
                    v.status = ST_BADPORT;
                end
            endcase
            expected_verdicts.push_back(v);
        endfunction

        function void check_field(input string name, input int unsigned exp_v,
                                  input int unsigned act_v);
            if (exp_v != act_v) begin
                if (errors < MAX_REPORTS)
                    $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one result item with the oldest prediction
        function void check_verdict(input logic [PORT_W-1:0] port,
                                    input logic [HANDLE_W-1:0] handle,
                                    input logic rel_valid,
                                    input logic [HANDLE_W-1:0] rel_handle,
                                    input logic [STATUS_W-1:0] status);
            packet_verdict_t v;
            if (expected_verdicts.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $error("result item with no expectation waiting");
                errors++;
                return;
            end
            v = expected_verdicts.pop_front();
            check_field("out_port", v.port, port);
            check_field("out_handle", v.handle, handle);
            check_field("released_valid", v.rel_valid, rel_valid);
            check_field("released_handle", v.rel_handle, rel_handle);
            check_field("status", v.status, status);
        endfunction

    endclass

endpackage

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for packet_replica_merge_table_core
// Drives packets over the valid/ready input, writes copies_needed over the
// APB port between phases, and checks every result item against the
// scoreboard's prediction. Covers directed corner cases, several copy counts,
// random replica traffic with stalls on both sides, and one entry counted
// all the way down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import prmt_pkg::*;
    import replica_merge_sb_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 150;
    localparam int DRAIN_CYCLES   = 4;
    localparam logic [PORT_W-1:0] IN_UNUSED6 = 3'd6;
    localparam logic [PORT_W-1:0] IN_UNUSED7 = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [PORT_W-1:0]   i_in_port;
    logic [ID_W-1:0]     i_packet_id;
    logic [HANDLE_W-1:0] i_packet_handle;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [PORT_W-1:0]   o_out_port;
    logic [HANDLE_W-1:0] o_out_handle;
    logic                o_released_valid;
    logic [HANDLE_W-1:0] o_released_handle;
    logic [STATUS_W-1:0] o_status;

    replica_merge_scoreboard sb;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;
    logic [ID_W-1:0] open_ids [$];

    packet_replica_merge_table_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_port         (i_in_port),
        .i_packet_id       (i_packet_id),
        .i_packet_handle   (i_packet_handle),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_port        (o_out_port),
        .o_out_handle      (o_out_handle),
        .o_released_valid  (o_released_valid),
        .o_released_handle (o_released_handle),
        .o_status          (o_status)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [PORT_W-1:0] pick_return_port();
        case ($urandom_range(0, 3))
            0:       return IN_P1_TO_SERVER;
            1:       return IN_P2_TO_SERVER;
            2:       return IN_P1_TO_CLIENT;
            default: return IN_P2_TO_CLIENT;
        endcase
    endfunction

    // offer one packet, hold it until accepted, then maybe pause
    task automatic offer_packet(input logic [PORT_W-1:0] port, input logic [ID_W-1:0] id,
                                input logic [HANDLE_W-1:0] handle);
        int pause;
        i_in_valid      <= 1'b1;
        i_in_port       <= port;
        i_packet_id     <= id;
        i_packet_handle <= handle;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_packet(port, id, handle);
        pause = ($urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (pause > 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    // wait until every predicted item is back, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write of copies_needed: setup then access
    task automatic write_copies_needed(input logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_COPIES_NEEDED * 4);
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.copies_needed = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // corner cases at the reset copy count of two
    task automatic directed_cases();
        offer_packet(IN_CLIENT, 16'h0000, 16'hFFFF);
        offer_packet(IN_SERVER, 16'h0000, 16'h0001);
        offer_packet(IN_P1_TO_SERVER, 16'h0000, 16'h1234);
        offer_packet(IN_P2_TO_SERVER, 16'h0000, 16'h0000);
        offer_packet(IN_P1_TO_SERVER, 16'h0000, 16'hFFFF);
        offer_packet(IN_SERVER, 16'hFFFF, 16'h0000);
        offer_packet(IN_P2_TO_CLIENT, 16'hFFFF, 16'hAAAA);
        offer_packet(IN_P1_TO_CLIENT, 16'hFFFF, 16'h5555);
        offer_packet(IN_UNUSED6, 16'hFFFF, 16'hFFFF);
        offer_packet(IN_UNUSED7, 16'h0000, 16'h0000);
        offer_packet(IN_P2_TO_CLIENT, 16'hFFFF, 16'h0F0F);
        offer_packet(IN_CLIENT, 16'h5555, 16'hAAAA);
        offer_packet(IN_P2_TO_SERVER, 16'h5555, 16'h5555);
        offer_packet(IN_P2_TO_CLIENT, 16'h5555, 16'hFFFF);
        offer_packet(IN_P1_TO_CLIENT, 16'hAAAA, 16'h00FF);
    endtask

    // random replica traffic: mostly complete exchanges, some noise
    task automatic random_traffic(input int count);
        int n;
        int roll;
        int k;
        logic [ID_W-1:0] id;
        bit was_free;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 25 || open_ids.size() == 0) begin
                // new exchange, sometimes from a tiny id pool to collide
                id = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 15))
                                                 : 16'($urandom);
                was_free = (sb.copies_left[id] == '0) && (sb.live_entries < TABLE_ENTRIES);
                offer_packet($urandom_range(0, 1) ? IN_SERVER : IN_CLIENT, id, 16'($urandom));
                if (was_free) open_ids.push_back(id);
            end else if (roll < 85) begin
                // replica coming back on an open entry
                k  = $urandom_range(0, open_ids.size() - 1);
                id = open_ids[k];
                offer_packet(pick_return_port(), id, 16'($urandom));
                if (sb.copies_left[id] == '0) open_ids.delete(k);
            end else if (roll < 90) begin
                id = open_ids[$urandom_range(0, open_ids.size() - 1)];
                offer_packet($urandom_range(0, 1) ? IN_SERVER : IN_CLIENT, id, 16'($urandom));
            end else if (roll < 96) begin
                id = 16'($urandom);
                offer_packet(pick_return_port(), id, 16'($urandom));
                for (k = 0; k < open_ids.size(); k++)
                    if (open_ids[k] == id && sb.copies_left[id] == '0) open_ids.delete(k);
            end else begin
                offer_packet($urandom_range(0, 1) ? IN_UNUSED7 : IN_UNUSED6,
                             16'($urandom), 16'($urandom));
            end
        end
    endtask

    // one entry counted all the way down from 255
    task automatic long_count_run();
        int k;
        logic [ID_W-1:0] id;
        id = 16'($urandom);
        while (sb.copies_left[id] != '0) id = id + 16'd1;
        offer_packet(IN_SERVER, id, 16'($urandom));
        for (k = 0; k < 255; k++)
            offer_packet(k[0] ? IN_P1_TO_CLIENT : IN_P2_TO_CLIENT, id, 16'($urandom));
    endtask

    // main sequence
    initial begin : stimulus
        sb = new();
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_in_valid      <= 1'b0;
        i_in_port       <= '0;
        i_packet_id     <= '0;
        i_packet_handle <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_cases();
        random_traffic(300);
        drain_results();

        write_copies_needed(8'd0);
        random_traffic(250);
        drain_results();

        write_copies_needed(8'd255);
        long_count_run();
        drain_results();

        write_copies_needed(8'd1);
        random_traffic(300);
        drain_results();

        write_copies_needed(8'($urandom_range(3, 6)));
        random_traffic(350);
        drain_results();

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_verdicts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side: random stalls, one long hold-off to back up the input
    initial begin : result_side
        int stretch;
        bit hold_done;
        hold_done = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                i_out_ready <= 1'b1;
                stretch = $urandom_range(1, 40);
                repeat (stretch) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_verdict(o_out_port, o_out_handle, o_released_valid,
                             o_released_handle, o_status);
            results_seen++;
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
hdl/prmt_pkg.sv
hdl/prmt_ram.sv
hdl/prmt_update.sv
hdl/packet_replica_merge_table_core.sv
tb/replica_merge_sb_pkg.sv
tb/tb.sv
